@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the edge latch table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of aclk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

@@ rtl/core/gelt_pkg.sv @@
// ----------------------------------------------------------------------------
// GPIO edge latch table package
// Request and status codes, defaults and the structs shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package gelt_pkg;

    localparam int DEF_NUM_SLOTS = 8;
    localparam int DEF_NUM_PINS  = 32;

    localparam int PIN_W    = 5;
    localparam int LEVELS_W = 32;
    localparam int HANDLE_W = 8;

    localparam logic [HANDLE_W-1:0] NO_HANDLE = 8'hFF;

    typedef enum logic [1:0] {
        REQ_REGISTER   = 2'd0,
        REQ_UNREGISTER = 2'd1,
        REQ_TICK       = 2'd2,
        REQ_READ       = 2'd3
    } req_e_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HANDLE = 2'd1,
        ST_FULL       = 2'd2
    } status_e_t;

    // Edge flag bit positions.
    localparam int EDGE_RISE_BIT = 0;
    localparam int EDGE_FALL_BIT = 1;

    // Request kind broadcast to every lane, already qualified by acceptance.
    typedef struct packed {
        logic do_register;
        logic do_unregister;
        logic do_tick;
        logic do_read;
    } lane_cmd_t;

    typedef struct packed {
        status_e_t           status;
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          flags;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/core/gelt_lane.sv @@
// ----------------------------------------------------------------------------
// Edge latch lane
// One table slot: watched pin, edge mask, sticky flags, previous level, in use.
// ----------------------------------------------------------------------------
`default_nettype none

module gelt_lane #(
    parameter int NUM_PINS = gelt_pkg::DEF_NUM_PINS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire gelt_pkg::lane_cmd_t           cmd,
    input  wire logic                          grant,
    input  wire logic                          hit,
    input  wire logic [gelt_pkg::PIN_W-1:0]    pin_select,
    input  wire logic [1:0]                    edge_enable,
    input  wire logic                          start_level,
    input  wire logic [gelt_pkg::LEVELS_W-1:0] pin_levels,
    output logic                               in_use,
    output logic [1:0]                         flags
);

    logic [gelt_pkg::PIN_W-1:0] pin_reg, pin_next;
    logic [1:0]                 mask_reg, mask_next;
    logic [1:0]                 flags_reg, flags_next;
    logic                       prev_reg, prev_next;
    logic                       in_use_reg, in_use_next;

    logic       cur_level;
    logic [1:0] seen;

    // Pins beyond the configured count always sample low.
    assign cur_level = (int'(pin_reg) < NUM_PINS) ? pin_levels[pin_reg] : 1'b0;

    always_comb begin
        seen                         = '0;
        seen[gelt_pkg::EDGE_RISE_BIT] = cur_level & ~prev_reg;
        seen[gelt_pkg::EDGE_FALL_BIT] = ~cur_level & prev_reg;
    end

    always_comb begin
        pin_next    = pin_reg;
        mask_next   = mask_reg;
        flags_next  = flags_reg;
        prev_next   = prev_reg;
        in_use_next = in_use_reg;
        if (cmd.do_register && grant) begin
            pin_next    = pin_select;
            mask_next   = edge_enable;
            flags_next  = '0;
            prev_next   = start_level;
            in_use_next = 1'b1;
        end else if (cmd.do_unregister && hit) begin
            in_use_next = 1'b0;
        end else if (cmd.do_read && hit) begin
            flags_next = '0;
        end else if (cmd.do_tick && in_use_reg) begin
            flags_next = flags_reg | (seen & mask_reg);
            prev_next  = cur_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_reg    <= '0;
            mask_reg   <= '0;
            flags_reg  <= '0;
            prev_reg   <= 1'b0;
            in_use_reg <= 1'b0;
        end else begin
            pin_reg    <= pin_next;
            mask_reg   <= mask_next;
            flags_reg  <= flags_next;
            prev_reg   <= prev_next;
            in_use_reg <= in_use_next;
        end
    end

    assign in_use = in_use_reg;
    assign flags  = flags_reg;

endmodule

`default_nettype wire

@@ rtl/core/gelt_merge.sv @@
// ----------------------------------------------------------------------------
// Edge latch lane merge
// Finds the lowest free slot, checks handles and forms the request result.
// ----------------------------------------------------------------------------
`default_nettype none

module gelt_merge #(
    parameter int NUM_SLOTS = gelt_pkg::DEF_NUM_SLOTS
) (
    input  wire gelt_pkg::req_e_t                req_type,
    input  wire logic [gelt_pkg::HANDLE_W-1:0]   slot_handle,
    input  wire logic [NUM_SLOTS-1:0]            in_use,
    input  wire logic [NUM_SLOTS-1:0][1:0]       flags,
    output logic [NUM_SLOTS-1:0]                 grant,
    output logic [NUM_SLOTS-1:0]                 hit,
    output gelt_pkg::result_t                    result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    logic              found;
    logic [SLOT_W-1:0] free_idx;
    logic [SLOT_W-1:0] h_idx;
    logic              h_valid;

    // Lowest free slot wins.
    always_comb begin
        grant    = '0;
        found    = 1'b0;
        free_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!in_use[i] && !found) begin
                grant[i] = 1'b1;
                free_idx = SLOT_W'(i);
                found    = 1'b1;
            end
        end
    end

    assign h_idx   = slot_handle[SLOT_W-1:0];
    assign h_valid = (slot_handle < gelt_pkg::HANDLE_W'(NUM_SLOTS)) && in_use[h_idx];

    always_comb begin
        hit = '0;
        if (h_valid) begin
            hit[h_idx] = 1'b1;
        end
    end

    always_comb begin
        result.status = gelt_pkg::ST_OK;
        result.handle = gelt_pkg::NO_HANDLE;
        result.flags  = '0;
        case (req_type)
            gelt_pkg::REQ_REGISTER: begin
                if (found) begin
                    result.handle = gelt_pkg::HANDLE_W'(free_idx);
                end else begin
                    result.status = gelt_pkg::ST_FULL;
                end
            end
            gelt_pkg::REQ_UNREGISTER: begin
                if (!h_valid) begin
                    result.status = gelt_pkg::ST_BAD_HANDLE;
                end
            end
            gelt_pkg::REQ_READ: begin
                if (h_valid) begin
                    result.flags = flags[h_idx];
                end else begin
                    result.status = gelt_pkg::ST_BAD_HANDLE;
                end
            end
            default: begin
                result.status = gelt_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/gpio_edge_latch_table_top.sv @@
// Results: a result is registered in the output register, or in the skid entry while the output holds a waiting result.
// Throughput: one request per cycle while s_ready is high; every slot lane sees the request in the accepting cycle.
// An output register plus one skid entry let a request be taken while a result waits.
// Reset (synchronous, active low aresetn) frees every slot and clears all flags.
// ----------------------------------------------------------------------------
// GPIO edge latch table
// Slot lanes that latch enabled pin edges into sticky flags, with a merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gpio_edge_latch_table_top #(
    parameter int NUM_SLOTS = gelt_pkg::DEF_NUM_SLOTS,
    parameter int NUM_PINS  = gelt_pkg::DEF_NUM_PINS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_req_type,
    input  wire logic [gelt_pkg::PIN_W-1:0]    s_pin_select,
    input  wire logic [1:0]                    s_edge_enable,
    input  wire logic                          s_start_level,
    input  wire logic [gelt_pkg::HANDLE_W-1:0] s_slot_handle,
    input  wire logic [gelt_pkg::LEVELS_W-1:0] s_pin_levels,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [gelt_pkg::HANDLE_W-1:0]      m_handle_out,
    output logic [1:0]                         m_edge_flags
);

    gelt_pkg::req_e_t            req;
    gelt_pkg::lane_cmd_t         cmd;
    gelt_pkg::result_t           result;
    logic                        fire;
    logic [NUM_SLOTS-1:0]        grant;
    logic [NUM_SLOTS-1:0]        hit;
    logic [NUM_SLOTS-1:0]        in_use;
    logic [NUM_SLOTS-1:0][1:0]   flags;
    logic [NUM_SLOTS-1:0]        claim;

    gelt_pkg::result_t out_reg, out_next;
    gelt_pkg::result_t skid_reg, skid_next;
    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;

    assign req     = gelt_pkg::req_e_t'(s_req_type);
    assign s_ready = !skid_valid_reg;
    assign fire    = s_valid && s_ready;

    always_comb begin
        cmd.do_register   = fire && (req == gelt_pkg::REQ_REGISTER);
        cmd.do_unregister = fire && (req == gelt_pkg::REQ_UNREGISTER);
        cmd.do_tick       = fire && (req == gelt_pkg::REQ_TICK);
        cmd.do_read       = fire && (req == gelt_pkg::REQ_READ);
    end

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_lane
        gelt_lane #(
            .NUM_PINS (NUM_PINS)
        ) u_lane (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .grant         (grant[g]),
            .hit           (hit[g]),
            .pin_select    (s_pin_select),
            .edge_enable   (s_edge_enable),
            .start_level   (s_start_level),
            .pin_levels    (s_pin_levels),
            .in_use        (in_use[g]),
            .flags         (flags[g])
        );
    end

    gelt_merge #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_merge (
        .req_type    (req),
        .slot_handle (s_slot_handle),
        .in_use      (in_use),
        .flags       (flags),
        .grant       (grant),
        .hit         (hit),
        .result      (result)
    );

    // Output register with one skid entry behind it.
    always_comb begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (skid_valid_reg && m_ready) begin
            out_next        = skid_reg;
            out_valid_next  = 1'b1;
            skid_valid_next = 1'b0;
        end
        if (fire) begin
            if (!out_valid_reg || m_ready) begin
                out_next       = result;
                out_valid_next = 1'b1;
            end else begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_handle_out = out_reg.handle;
    assign m_edge_flags = out_reg.flags;

    // Slot taken by an accepted register request.
    assign claim = cmd.do_register ? grant : '0;

    `ASSERT_CLK(a_skid_behind_out, skid_valid_reg |-> out_valid_reg, "skid entry without output")
    `ASSERT_CLK(a_grant_onehot, $onehot0(grant), "more than one free slot granted")
    `ASSERT_CLK(a_claim_held, (claim != '0) |=> ($past(claim) & ~in_use) == '0, "slot left free")
    `ASSERT_NEVER(a_hit_free_slot, (hit & ~in_use) != '0, "handle hit on a free slot")

endmodule

`default_nettype wire
